[rtl/skit_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted key index table package
// Shared types, codes and constants of the sorted key index table.
// ----------------------------------------------------------------------------
package skit_pkg;

   localparam int DefaultCapacity = 256;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;
   localparam logic [1:0] MODE_READ   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_DUPLICATE = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] key_word0;
      logic [63:0] key_word1;
      logic [63:0] key_word2;
      logic [63:0] key_word3;
      logic [7:0]  position;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] slot;
      logic [8:0] entries;
   } rsp_type;

   // Datapath operations issued by the controller.
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1; // latch request, reset search bounds
   localparam logic [2:0] OP_PROBE  = 3'd2; // read entry at mid
   localparam logic [2:0] OP_STEP   = 3'd3; // compare read data, narrow bounds
   localparam logic [2:0] OP_READ   = 3'd4; // read entry at or below cursor, or at position
   localparam logic [2:0] OP_MOVE   = 3'd5; // write read data at target
   localparam logic [2:0] OP_WRNEW  = 3'd6; // write new key at found position
   localparam logic [2:0] OP_FIXUP  = 3'd7; // write decremented slot if above

   typedef struct packed {
      logic [2:0] op;
      logic       up;       // shift direction: 1 moves entries toward the end
      logic       cur_init; // set cursor from the search position or count
      logic       count_inc;
      logic       count_dec;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic hit;
      logic empty_range;  // lo has reached hi
      logic shift_done;
      logic fix_done;
      logic full;
      logic pos_ok;
   } sts_type;

endpackage

[rtl/skit_if.sv]
// ----------------------------------------------------------------------------
// Sorted key index table channel
// Valid and ready handshake carrying one payload item.
// ----------------------------------------------------------------------------
interface skit_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/skit_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted key index table controller
// Sequences search, shift, slot fixup and position read passes for one item at a time.
// ----------------------------------------------------------------------------
module skit_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic              rsp_free,
   output logic              done,
   output skit_pkg::cmd_type cmd,
   input  skit_pkg::sts_type sts
);
   import skit_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PROBE  = 4'd1;
   localparam logic [3:0] S_STEP   = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_SREAD  = 4'd4;
   localparam logic [3:0] S_SWAIT  = 4'd5;
   localparam logic [3:0] S_SMOVE  = 4'd6;
   localparam logic [3:0] S_NEW    = 4'd7;
   localparam logic [3:0] S_FREAD  = 4'd8;
   localparam logic [3:0] S_FWAIT  = 4'd9;
   localparam logic [3:0] S_FWRITE = 4'd10;
   localparam logic [3:0] S_RREAD  = 4'd11;
   localparam logic [3:0] S_RWAIT  = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_LOOKUP;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               mode_in  = req_mode;
               state_in = (req_mode == MODE_READ) ? S_RREAD : S_PROBE;
            end
         end
         S_PROBE: begin
            if (sts.empty_range) begin
               state_in = S_DECIDE;
            end else begin
               cmd.op   = OP_PROBE;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cmd.op   = OP_STEP;
            state_in = S_PROBE;
            if (sts.hit) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            if (mode_ff == MODE_INSERT && !sts.full && !sts.hit) begin
               cmd.cur_init = 1'b1;
               cmd.up       = 1'b1;
               state_in     = S_SREAD;
            end else if (mode_ff == MODE_REMOVE && sts.hit) begin
               cmd.cur_init = 1'b1;
               state_in     = S_SREAD;
            end
         end
         S_SREAD: begin
            cmd.up = (mode_ff == MODE_INSERT);
            if (sts.shift_done) begin
               state_in = (mode_ff == MODE_INSERT) ? S_NEW : S_FREAD;
               if (mode_ff == MODE_REMOVE) begin
                  cmd.count_dec = 1'b1;
               end
            end else begin
               cmd.op   = OP_READ;
               state_in = S_SWAIT;
            end
         end
         S_SWAIT: begin
            state_in = S_SMOVE;
         end
         S_SMOVE: begin
            cmd.op   = OP_MOVE;
            cmd.up   = (mode_ff == MODE_INSERT);
            state_in = S_SREAD;
         end
         S_NEW: begin
            cmd.op        = OP_WRNEW;
            cmd.count_inc = 1'b1;
            state_in      = S_DONE;
         end
         S_FREAD: begin
            if (sts.fix_done) begin
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_READ;
               state_in = S_FWAIT;
            end
         end
         S_FWAIT: begin
            state_in = S_FWRITE;
         end
         S_FWRITE: begin
            cmd.op   = OP_FIXUP;
            state_in = S_FREAD;
         end
         S_RREAD: begin
            cmd.op   = OP_READ;
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hold here while the previous result still waits in the output register.
            if (rsp_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/skit_datapath.sv]
// ----------------------------------------------------------------------------
// Sorted key index table datapath
// Key and slot memories, search bounds, cursor, entry count and result.
// ----------------------------------------------------------------------------
module skit_datapath #(
   parameter int Capacity = skit_pkg::DefaultCapacity
) (
   input  logic              clock,
   input  logic              reset,
   input  skit_pkg::req_type req,
   input  skit_pkg::cmd_type cmd,
   input  logic              done,
   output skit_pkg::sts_type sts,
   output skit_pkg::rsp_type result
);
   import skit_pkg::*;

   localparam int AW = $clog2(Capacity);
   localparam int CW = $clog2(Capacity + 1);

   // Entry memories, one read and one write port each.
   logic [255:0]  key_mem  [Capacity];
   logic [AW-1:0] slot_mem [Capacity];
   logic [255:0]  rd_key_ff;
   logic [AW-1:0] rd_slot_ff;

   logic [255:0]  key_ff;
   logic [1:0]    mode_ff;
   logic [7:0]    pos_ff;
   logic          full_ff;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, count_ff, count_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] found_slot_ff, found_slot_in;
   logic [CW-1:0] mid;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          rd_en, wr_en;
   logic [255:0]  wr_key;
   logic [AW-1:0] wr_slot;
   logic          key_we;
   logic          lt, eq;
   rsp_type       result_in;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lt  = rd_key_ff < key_ff;
   assign eq  = rd_key_ff == key_ff;

   // Memory address and write data selection.
   always_comb begin
      rd_en   = 1'b0;
      wr_en   = 1'b0;
      key_we  = 1'b1;
      rd_addr = mid[AW-1:0];
      wr_addr = cur_ff[AW-1:0];
      wr_key  = rd_key_ff;
      wr_slot = rd_slot_ff;
      case (cmd.op)
         OP_PROBE: rd_en = 1'b1;
         OP_READ: begin
            rd_en = 1'b1;
            if (mode_ff == MODE_READ) begin
               rd_addr = AW'(pos_ff);
            end else if (mode_ff == MODE_INSERT) begin
               rd_addr = AW'(cur_ff - 1'b1);
            end else begin
               rd_addr = cur_ff[AW-1:0];
            end
         end
         OP_MOVE: begin
            wr_en = 1'b1;
            if (mode_ff == MODE_REMOVE) begin
               wr_addr = AW'(cur_ff - 1'b1);
            end
         end
         OP_WRNEW: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff[AW-1:0];
            wr_key  = key_ff;
            wr_slot = count_ff[AW-1:0];
         end
         OP_FIXUP: begin
            key_we  = 1'b0;
            wr_en   = rd_slot_ff > found_slot_ff;
            wr_slot = rd_slot_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (key_we) begin
            key_mem[wr_addr] <= wr_key;
         end
         slot_mem[wr_addr] <= wr_slot;
      end
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_slot_ff <= slot_mem[rd_addr];
      end
   end

   // Search bounds, cursor and count.
   always_comb begin
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cur_in        = cur_ff;
      hit_in        = hit_ff;
      count_in      = count_ff;
      found_slot_in = found_slot_ff;
      case (cmd.op)
         OP_LOAD: begin
            lo_in  = '0;
            hi_in  = count_ff;
            hit_in = 1'b0;
         end
         OP_STEP: begin
            if (eq) begin
               hit_in        = 1'b1;
               lo_in         = mid;
               found_slot_in = rd_slot_ff;
            end else if (lt) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
         end
         OP_MOVE: cur_in = cmd.up ? cur_ff - 1'b1 : cur_ff + 1'b1;
         OP_FIXUP: cur_in = cur_ff + 1'b1;
         default: ;
      endcase
      if (cmd.cur_init) begin
         cur_in = cmd.up ? count_ff : lo_ff + 1'b1;
      end
      if (cmd.count_dec) begin
         count_in = count_ff - 1'b1;
         cur_in   = '0;
      end
      if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cur_ff        <= cur_in;
      hit_ff        <= hit_in;
      found_slot_ff <= found_slot_in;
      // The full flag is taken at load so a filling insert still reports ok.
      if (cmd.op == OP_LOAD) begin
         key_ff  <= {req.key_word0, req.key_word1, req.key_word2, req.key_word3};
         mode_ff <= req.mode;
         pos_ff  <= req.position;
         full_ff <= count_ff == CW'(Capacity);
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.search_done = hit_ff || (lo_ff == hi_ff);
      sts.hit         = (cmd.op == OP_STEP) ? eq : hit_ff;
      sts.empty_range = lo_ff == hi_ff;
      sts.shift_done  = (mode_ff == MODE_INSERT) ? (cur_ff == lo_ff) : (cur_ff == count_ff);
      sts.fix_done    = cur_ff == count_ff;
      sts.full        = full_ff;
      sts.pos_ok      = 32'(pos_ff) < 32'(count_ff);
   end

   // Result assembly at the end of the item.
   always_comb begin
      result_in         = '0;
      result_in.entries = 9'(count_ff);
      result_in.status  = ST_OK;
      case (mode_ff)
         MODE_LOOKUP: begin
            if (hit_ff) result_in.slot = 8'(found_slot_ff);
            else result_in.status = ST_NOT_FOUND;
         end
         MODE_INSERT: begin
            if (full_ff) result_in.status = ST_FULL;
            else if (hit_ff) result_in.status = ST_DUPLICATE;
            else result_in.slot = 8'(count_ff - 1'b1);
         end
         MODE_REMOVE: begin
            if (hit_ff) result_in.slot = 8'(found_slot_ff);
            else result_in.status = ST_NOT_FOUND;
         end
         default: begin
            if (sts.pos_ok && 32'(pos_ff) < Capacity) result_in.slot = 8'(rd_slot_ff);
            else result_in.status = ST_RANGE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (done) begin
         result <= result_in;
      end
   end

endmodule

[rtl/sorted_key_index_table_top.sv]
// ----------------------------------------------------------------------------
// Sorted key index table
// Sorted 256-bit key table with binary search lookup, insert, remove and read by position.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  req     | in        | mode, key_word0..3, position
//  rsp     | out       | status, slot, entries
//
// A lookup is a binary search: each search step reads the key memory and
// compares the registered word. Insert and remove also move entries one at a
// time, each read and then written, and remove adds a slot renumbering pass
// over the entries. Reset is synchronous and clears the entry count; the
// memories need no clearing. A stalled result holds in the output register
// while the next item is accepted and worked; that item only waits in its
// last cycle until the held result is taken.
module sorted_key_index_table_top #(
   parameter int Capacity = skit_pkg::DefaultCapacity
) (
   input logic clock,
   input logic reset,
   skit_if.sink   req,
   skit_if.source rsp
);
   import skit_pkg::*;

   cmd_type cmd;
   sts_type sts;
   rsp_type result;
   logic    done, ctrl_ready, rsp_valid_ff, rsp_free;

   // The output register can take a new result when empty or being emptied.
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   skit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ctrl_ready),
      .req_mode  (req.payload.mode),
      .rsp_free  (rsp_free),
      .done      (done),
      .cmd       (cmd),
      .sts       (sts)
   );

   skit_datapath #(.Capacity(Capacity)) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req.payload),
      .cmd    (cmd),
      .done   (done),
      .sts    (sts),
      .result (result)
   );

   assign req.ready = ctrl_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.payload = result;
   assign rsp.valid   = rsp_valid_ff;

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp.payload))
      else $error("result changed while stalled");
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff) else $error("result lost");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 32'(rsp.payload.entries) <= Capacity) else $error("count overflow");

endmodule
